>>> hw/rtl/ksm_pkg.sv
// shared types and constants of the scalar kalman smoother
`default_nettype none

package ksm_pkg;

    // width of variances and noise registers, unsigned q8.24
    localparam int VAR_W     = 32;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VARIANCE = 2'd2;

    // register values after reset
    localparam logic [VAR_W-1:0] RST_PROCESS_NOISE    = 32'd168;
    localparam logic [VAR_W-1:0] RST_MEASURE_NOISE    = 32'd167772;
    localparam logic [VAR_W-1:0] RST_INITIAL_VARIANCE = 32'd16777216;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MUL_EST,
        ST_MUL_VAR,
        ST_FINISH
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic prepare;
        logic div_step;
        logic mul_est;
        logic mul_var;
        logic commit;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic restart;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

>>> hw/rtl/ksm_ctrl.sv
// sequencer of the kalman smoother: input handshake and step commands
`default_nettype none

module ksm_ctrl #(
    parameter int VAR_FRAC_BITS = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ksm_pkg::t_sts i_sts,
    output ksm_pkg::t_cmd      o_cmd
);

    localparam int CW = $clog2(VAR_FRAC_BITS + 1);
    localparam logic [CW-1:0] DIV_LAST = CW'(VAR_FRAC_BITS);

    ksm_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ksm_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ksm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ksm_pkg::ST_PREP;
                end
            end
            ksm_pkg::ST_PREP: begin
                // restart items skip the update arithmetic
                o_cmd.prepare = 1'b1;
                n_cnt         = '0;
                n_state       = i_sts.restart ? ksm_pkg::ST_FINISH : ksm_pkg::ST_DIV;
            end
            ksm_pkg::ST_DIV: begin
                // one quotient bit per cycle, integer bit first
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = ksm_pkg::ST_MUL_EST;
                end
            end
            ksm_pkg::ST_MUL_EST: begin
                o_cmd.mul_est = 1'b1;
                n_state       = ksm_pkg::ST_MUL_VAR;
            end
            ksm_pkg::ST_MUL_VAR: begin
                o_cmd.mul_var = 1'b1;
                n_state       = ksm_pkg::ST_FINISH;
            end
            ksm_pkg::ST_FINISH: begin
                // wait for the output register to free up
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ksm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ksm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/ksm_dpath.sv
// datapath of the kalman smoother: registers, gain divider, shared multiplier
`default_nettype none

module ksm_dpath #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int VAR_FRAC_BITS = 24
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire ksm_pkg::t_cmd                        i_cmd,
    output ksm_pkg::t_sts                             o_sts,
    input  wire logic                                 i_cfg_valid,
    input  wire logic [ksm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [ksm_pkg::VAR_W-1:0]            i_cfg_data,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       i_sample,
    input  wire logic                                 i_start_req,
    input  wire logic                                 i_out_ready,
    output logic                                      o_out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]            o_estimate,
    output logic [VAR_FRAC_BITS:0]                    o_gain,
    output logic [ksm_pkg::VAR_W-1:0]                 o_variance
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int FB   = VAR_FRAC_BITS;
    localparam int GW   = FB + 1;
    localparam int VW   = ksm_pkg::VAR_W;
    localparam int SUMW = VW + 1;
    localparam int RW   = VW + 2;
    localparam int BW   = (SW + 1 > VW + 1) ? SW + 1 : VW + 1;
    localparam int AW   = FB + 2;
    localparam int PW   = AW + BW;

    localparam logic [GW-1:0] ONE_FX = {1'b1, {FB{1'b0}}};
    localparam logic signed [PW-1:0] HALF_FX = {{(PW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

    // configuration and filter state
    logic [VW-1:0]          r_proc_noise, r_meas_noise, r_init_var;
    logic signed [SW-1:0]   r_est;
    logic [VW-1:0]          r_var;
    logic                   r_primed;
    logic                   r_out_valid;

    // per item working registers
    logic signed [SW-1:0]   r_sample;
    logic                   r_restart;
    logic [VW-1:0]          r_pred;
    logic [SUMW-1:0]        r_sum;
    logic [RW-1:0]          r_rem;
    logic [GW-1:0]          r_quo;
    logic signed [PW-1:0]   r_prod;
    logic signed [SW-1:0]   r_est_new;
    logic signed [SW-1:0]   r_out_est;
    logic [GW-1:0]          r_out_gain;
    logic [VW-1:0]          r_out_var;

    logic [SUMW-1:0]        w_pred_raw;
    logic [VW-1:0]          w_pred;
    logic [SUMW-1:0]        w_sum;
    logic                   w_ge;
    logic [RW-1:0]          w_rem_sub;
    logic [GW-1:0]          w_gain;
    logic signed [BW-1:0]   w_diff;
    logic signed [AW-1:0]   w_mul_a;
    logic signed [BW-1:0]   w_mul_b;
    logic signed [PW-1:0]   w_prod;
    logic signed [PW-1:0]   w_round;
    logic signed [BW-1:0]   w_est_sum;

    // predicted variance with saturation, and divisor
    assign w_pred_raw = {1'b0, r_var} + {1'b0, r_proc_noise};
    assign w_pred     = w_pred_raw[VW] ? {VW{1'b1}} : w_pred_raw[VW-1:0];
    assign w_sum      = {1'b0, w_pred} + {1'b0, r_meas_noise};

    // restoring division step
    assign w_ge      = (r_rem >= RW'(r_sum));
    assign w_rem_sub = w_ge ? (r_rem - RW'(r_sum)) : r_rem;

    // zero divisor gives zero gain
    assign w_gain = (r_sum == '0) ? '0 : r_quo;

    // shared multiplier: gain by innovation, then (1 - gain) by prediction
    assign w_diff  = BW'(r_sample) - BW'(r_est);
    assign w_mul_a = i_cmd.mul_est ? signed'({1'b0, w_gain})
                                   : signed'({1'b0, ONE_FX - w_gain});
    assign w_mul_b = i_cmd.mul_est ? w_diff : signed'(BW'(r_pred));
    assign w_prod  = w_mul_a * w_mul_b;

    // round to nearest, ties up, on the registered product
    assign w_round   = (r_prod + HALF_FX) >>> FB;
    assign w_est_sum = BW'(r_est) + w_round[BW-1:0];

    // control state, configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc_noise <= ksm_pkg::RST_PROCESS_NOISE;
            r_meas_noise <= ksm_pkg::RST_MEASURE_NOISE;
            r_init_var   <= ksm_pkg::RST_INITIAL_VARIANCE;
            r_est        <= '0;
            r_var        <= '0;
            r_primed     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ksm_pkg::CFG_PROCESS_NOISE:    r_proc_noise <= i_cfg_data;
                    ksm_pkg::CFG_MEASURE_NOISE:    r_meas_noise <= i_cfg_data;
                    ksm_pkg::CFG_INITIAL_VARIANCE: r_init_var   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_primed    <= 1'b1;
                r_out_valid <= 1'b1;
                if (r_restart) begin
                    r_est <= r_sample;
                    r_var <= r_init_var;
                end else begin
                    r_est <= r_est_new;
                    r_var <= w_round[VW-1:0];
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and output payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample  <= i_sample;
            r_restart <= i_start_req | ~r_primed;
        end
        if (i_cmd.prepare) begin
            r_pred <= w_pred;
            r_sum  <= w_sum;
            r_rem  <= RW'(w_pred);
            r_quo  <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= {w_rem_sub[RW-2:0], 1'b0};
            r_quo <= {r_quo[GW-2:0], w_ge};
        end
        if (i_cmd.mul_est) begin
            r_prod <= w_prod;
        end
        if (i_cmd.mul_var) begin
            r_est_new <= w_est_sum[SW-1:0];
            r_prod    <= w_prod;
        end
        if (i_cmd.commit) begin
            if (r_restart) begin
                r_out_est  <= r_sample;
                r_out_gain <= '0;
                r_out_var  <= r_init_var;
            end else begin
                r_out_est  <= r_est_new;
                r_out_gain <= w_gain;
                r_out_var  <= w_round[VW-1:0];
            end
        end
    end

    assign o_sts.restart  = r_restart;
    assign o_sts.out_busy = r_out_valid & ~i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_estimate     = r_out_est;
    assign o_gain         = r_out_gain;
    assign o_variance     = r_out_var;

endmodule

`default_nettype wire

>>> hw/rtl/scalar_kalman_smoother_unit.sv
// Scalar Kalman filter with a constant-position model, one result per sample.
// Input item (s_axis): sample in tdata, start_req in tuser. Result item (m_axis):
// estimate, gain and variance packed into tdata. Configuration writes on the cfg
// channel (index 0 process noise, 1 measurement noise, 2 initial variance) are
// always taken; unknown indexes are dropped. Write them only while the block is idle.
// The first item after reset, or one with start_req set, skips the update arithmetic
// and gives its result after the prepare step. Any other item passes through the
// prepare step and the gain divider, which produces one quotient bit per cycle,
// followed by two passes through one multiplier, before its result is loaded.
// One item is in work at a time; the next is taken the cycle after a result is
// loaded into the output register.
// A result waits in the output register while m_axis_tready is low; the following
// item is still accepted and worked on, and holds before its result until the
// register is free.
// Reset clears estimate, variance and the primed flag and restores the default
// noise settings; the first item after reset always restarts the filter.
`default_nettype none

module scalar_kalman_smoother_unit #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int VAR_FRAC_BITS = 24
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    // sample
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,  // sample
    input  wire logic                                    s_axis_tuser,  // start_req
    // estimate, gain, variance
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    output logic [((SAMPLE_WIDTH+VAR_FRAC_BITS+1+ksm_pkg::VAR_W+7)/8)*8-1:0]
                                                         m_axis_tdata,
    // m_axis_tdata from bit 0: estimate, gain, variance, zero padding
    // configuration writes
    input  wire logic                                    i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  wire logic [ksm_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  wire logic [ksm_pkg::VAR_W-1:0]               i_cfg_data
);

    localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + VAR_FRAC_BITS + 1 + ksm_pkg::VAR_W + 7) / 8) * 8;

    ksm_pkg::t_cmd                  w_cmd;
    ksm_pkg::t_sts                  w_sts;
    logic signed [SAMPLE_WIDTH-1:0] w_estimate;
    logic [VAR_FRAC_BITS:0]         w_gain;
    logic [ksm_pkg::VAR_W-1:0]      w_variance;

    // sequencer
    ksm_ctrl #(
        .VAR_FRAC_BITS (VAR_FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // arithmetic and state
    ksm_dpath #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .VAR_FRAC_BITS (VAR_FRAC_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_start_req (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_estimate  (w_estimate),
        .o_gain      (w_gain),
        .o_variance  (w_variance)
    );

    // pack the result item
    assign m_axis_tdata = OUT_TDATA_W'({w_variance, w_gain, w_estimate});
    assign o_cfg_ready  = 1'b1;

endmodule

`default_nettype wire

>>> hw/rtl/ksm_checker.sv
// port-level checks of the kalman smoother and their binding
`default_nettype none

module ksm_checker #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int VAR_FRAC_BITS = 24
) (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 s_axis_tvalid,
    input wire logic                                 s_axis_tready,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [((SAMPLE_WIDTH+VAR_FRAC_BITS+1+ksm_pkg::VAR_W+7)/8)*8-1:0]
                                                     m_axis_tdata
);

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result item visible after reset");

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result item changed");

    // one item in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // a new result only appears when the last item has finished
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready && !$past(s_axis_tready))
        else $error("result item appeared outside item completion");

endmodule

bind scalar_kalman_smoother_unit ksm_checker #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .VAR_FRAC_BITS (VAR_FRAC_BITS)
) u_ksm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> dv/scalar_kalman_smoother_unit_tb.sv
// self-checking testbench for the scalar kalman smoother: directed and random items
`default_nettype none

// one filter result, estimate in the lowest bits as on m_axis_tdata
typedef struct packed {
    logic [ksm_pkg::VAR_W-1:0] variance;
    logic [24:0]               gain;
    logic signed [15:0]        estimate;
} kalman_result_t;

localparam longint unsigned GAIN_ONE  = 64'h0000_0000_0100_0000;
localparam longint unsigned HALF_UNIT = 64'h0000_0000_0080_0000;

// fixed-point filter predictor and store of expected results
class kalman_scoreboard;
    logic [ksm_pkg::VAR_W-1:0] q_noise;
    logic [ksm_pkg::VAR_W-1:0] r_noise;
    logic [ksm_pkg::VAR_W-1:0] p_init;
    logic signed [15:0]        position;
    logic [ksm_pkg::VAR_W-1:0] spread;
    bit                        locked;
    kalman_result_t            pending_results[$];
    int                        mismatch_count;

    function new();
        q_noise        = ksm_pkg::RST_PROCESS_NOISE;
        r_noise        = ksm_pkg::RST_MEASURE_NOISE;
        p_init         = ksm_pkg::RST_INITIAL_VARIANCE;
        position       = '0;
        spread         = '0;
        locked         = 1'b0;
        mismatch_count = 0;
    endfunction

    function void set_register(logic [ksm_pkg::CFG_IDX_W-1:0] index,
                               logic [ksm_pkg::VAR_W-1:0] value);
        case (index)
            ksm_pkg::CFG_PROCESS_NOISE:    q_noise = value;
            ksm_pkg::CFG_MEASURE_NOISE:    r_noise = value;
            ksm_pkg::CFG_INITIAL_VARIANCE: p_init  = value;
            default: ;
        endcase
    endfunction

    // one predict/update step for an accepted sample item
    function void take_sample(logic signed [15:0] sample, logic start_req);
        logic [32:0]            pred_wide;
        logic [31:0]            pred;
        logic [32:0]            total;
        longint unsigned        quotient;
        logic [24:0]            gain;
        longint                 diff;
        longint                 prod;
        longint                 next_pos;
        longint unsigned        shrink;
        kalman_result_t         res;
        gain = '0;
        if (start_req || !locked) begin
            position = sample;
            spread   = p_init;
            locked   = 1'b1;
        end else begin
            // predicted variance saturates at full scale
            pred_wide = {1'b0, spread} + {1'b0, q_noise};
            pred      = pred_wide[32] ? '1 : pred_wide[31:0];
            total     = {1'b0, pred} + {1'b0, r_noise};
            // gain stays zero when the sum is zero
            if (total != '0) begin
                quotient = {8'd0, pred, 24'd0} / {31'd0, total};
                gain     = (quotient > GAIN_ONE) ? GAIN_ONE[24:0] : quotient[24:0];
            end
            // round to nearest, ties toward plus infinity
            diff     = longint'(sample) - longint'(position);
            prod     = longint'({39'd0, gain}) * diff + longint'(HALF_UNIT);
            next_pos = longint'(position) + (prod >>> 24);
            position = next_pos[15:0];
            shrink   = (GAIN_ONE - {39'd0, gain}) * {32'd0, pred} + HALF_UNIT;
            spread   = shrink[55:24];
        end
        res.estimate = position;
        res.gain     = gain;
        res.variance = spread;
        pending_results = {pending_results, res};
    endfunction

    function void flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %0s: expected %08h, got %08h", field, want, got);
    endfunction

    function void check_result(logic [79:0] word);
        kalman_result_t want;
        kalman_result_t got;
        got = word[72:0];
        if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result %h with no item outstanding", word);
            return;
        end
        want = pending_results.pop_front();
        if (got.estimate !== want.estimate)
            flag_mismatch("estimate", 32'(want.estimate), 32'(got.estimate));
        if (got.gain !== want.gain)
            flag_mismatch("gain", 32'(want.gain), 32'(got.gain));
        if (got.variance !== want.variance)
            flag_mismatch("variance", want.variance, got.variance);
    endfunction
endclass

module scalar_kalman_smoother_unit_tb;

    // longest run without any handshake: an update item plus a long output stall
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 90;
    localparam logic [ksm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // sample
    logic        s_axis_tuser;   // start_req
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // estimate, gain, variance, zero padding
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [ksm_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [ksm_pkg::VAR_W-1:0]     i_cfg_data;

    int tx_idle_pct  = 27;
    int rx_idle_pct  = 63;
    int stall_cycles = 0;
    int track        = 0;
    kalman_scoreboard sb;

    scalar_kalman_smoother_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random back-pressure and checking
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[scalar_kalman_smoother_unit] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // present one sample item, with a random gap first
    task automatic send_sample(logic [15:0] sample, logic start_req);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tuser  <= start_req;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.take_sample(sample, start_req);
    endtask

    task automatic write_register(logic [ksm_pkg::CFG_IDX_W-1:0] index,
                                  logic [ksm_pkg::VAR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.set_register(index, value);
    endtask

    task automatic load_settings(logic [31:0] q, logic [31:0] r, logic [31:0] p0);
        write_register(ksm_pkg::CFG_PROCESS_NOISE, q);
        write_register(ksm_pkg::CFG_MEASURE_NOISE, r);
        write_register(ksm_pkg::CFG_INITIAL_VARIANCE, p0);
        i_cfg_valid <= 1'b0;
    endtask

    // hold off the sender until every outstanding result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_setting();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0001_0000);
            2: return $urandom_range(32'h0000_1000, 32'h0200_0000);
            default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        endcase
    endfunction

    // mostly noisy readings of a slowly drifting position, some wild values
    function automatic logic [15:0] random_sample();
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 70) begin
            track = track + int'($urandom_range(0, 64)) - 32;
            if (track > 32767) track = 32767;
            if (track < -32768) track = -32768;
            v = track + int'($urandom_range(0, 1023)) - 512;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        end else if (pick < 92) begin
            return 16'($urandom());
        end
        return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    endfunction

    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= ksm_pkg::CFG_PROCESS_NOISE;
        i_cfg_data    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default settings; the first item restarts without start_req
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0800, 1'b0);
        drain_results();

        // all noise and initial variance zero: gain sum is zero
        write_register(CFG_UNUSED, 32'hFFFF_FFFF);
        load_settings(32'h0, 32'h0, 32'h0);
        send_sample(16'h1234, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        drain_results();

        // full scale everywhere: predicted variance saturates
        load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        drain_results();

        // no measurement noise: gain of exactly one
        load_settings(32'd4096, 32'h0, 32'h0100_0000);
        send_sample(16'h0100, 1'b1);
        send_sample(16'hF000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        drain_results();

        // gain of one half: rounding ties in both directions
        load_settings(32'h0, 32'h0100_0000, 32'h0100_0000);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        drain_results();

        // random phases, each under fresh settings
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase < 2) begin
                tx_idle_pct = 27;
                rx_idle_pct = 63;
            end else if (phase < 4) begin
                tx_idle_pct = 63;
                rx_idle_pct = 27;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_register(CFG_UNUSED, $urandom());
            load_settings(pick_setting(), pick_setting(), pick_setting());
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(random_sample(), $urandom_range(19) == 0);
            drain_results();
        end

        if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
            $display("[scalar_kalman_smoother_unit] OK");
        else
            $display("[scalar_kalman_smoother_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
